/* hw/rtl/sip_pkg.sv */
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants for the segment intersection block
// Input and result transaction structs, pipeline widths.
// ----------------------------------------------------------------------------
package sip_pkg;

	localparam int CW  = 32;   // coordinate width
	localparam int DW  = 33;   // difference width
	localparam int PW  = 66;   // product width of two differences
	localparam int XW  = 68;   // cross product width
	localparam int NW  = 100;  // num * |component| width
	localparam int QW  = 33;   // quotient width kept

	typedef struct packed {
		logic signed [CW-1:0] first_start_x;
		logic signed [CW-1:0] first_start_y;
		logic signed [CW-1:0] first_end_x;
		logic signed [CW-1:0] first_end_y;
		logic signed [CW-1:0] second_start_x;
		logic signed [CW-1:0] second_start_y;
		logic signed [CW-1:0] second_end_x;
		logic signed [CW-1:0] second_end_y;
	} sip_in_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] cross_x;
		logic signed [CW-1:0] cross_y;
	} sip_out_t;

	// Per-item context carried down the divider
	typedef struct packed {
		logic                 ok;
		logic                 neg_x;
		logic                 neg_y;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
	} sip_ctx_t;

endpackage

/* hw/rtl/sip_front.sv */
// ----------------------------------------------------------------------------
// sip_front: difference, cross product and straddle stages
// Stage 1 forms differences and special-case flags, stage 2 the six
// products, stage 3 the cross products and |b|, stage 4 the t range test
// and the split partial products of num by |b|, stage 5 the scaled
// numerators.
// ----------------------------------------------------------------------------
module sip_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld,
	input  sip_pkg::sip_in_t            din,
	output logic                        vld_out,
	output sip_pkg::sip_ctx_t           ctx_out,
	output logic [sip_pkg::NW-1:0]      nx_out,
	output logic [sip_pkg::NW-1:0]      ny_out,
	output logic [sip_pkg::XW-1:0]      den_out
);

	localparam int DW = sip_pkg::DW;
	localparam int PW = sip_pkg::PW;
	localparam int XW = sip_pkg::XW;
	localparam int NW = sip_pkg::NW;
	localparam int HW = XW / 2;  // split point of num for the partial products

	// stage 1: differences and degenerate flags
	logic                 v_s1, bad_s1;
	logic signed [DW-1:0] bx_s1, by_s1, px_s1, py_s1, qx_s1, qy_s1;
	logic signed [31:0]   ax_s1, ay_s1;
	logic                 bad_c;

	always_comb begin
		bad_c = (din.first_start_x == din.first_end_x && din.first_start_y == din.first_end_y)
			|| (din.second_start_x == din.second_end_x
				&& din.second_start_y == din.second_end_y)
			|| (din.first_start_x == din.second_start_x
				&& din.first_start_y == din.second_start_y)
			|| (din.first_end_x == din.second_start_x
				&& din.first_end_y == din.second_start_y)
			|| (din.first_start_x == din.second_end_x
				&& din.first_start_y == din.second_end_y)
			|| (din.first_end_x == din.second_end_x
				&& din.first_end_y == din.second_end_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		bad_s1 <= bad_c;
		ax_s1  <= din.first_start_x;
		ay_s1  <= din.first_start_y;
		bx_s1  <= DW'(din.first_end_x) - DW'(din.first_start_x);
		by_s1  <= DW'(din.first_end_y) - DW'(din.first_start_y);
		px_s1  <= DW'(din.second_start_x) - DW'(din.first_start_x);
		py_s1  <= DW'(din.second_start_y) - DW'(din.first_start_y);
		qx_s1  <= DW'(din.second_end_x) - DW'(din.first_start_x);
		qy_s1  <= DW'(din.second_end_y) - DW'(din.first_start_y);
	end

	// stage 2: products
	logic                 v_s2, bad_s2;
	logic signed [PW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [DW-1:0] bx_s2, by_s2;
	logic signed [31:0]   ax_s2, ay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		bad_s2 <= bad_s1;
		m0_s2  <= PW'(bx_s1) * PW'(py_s1);
		m1_s2  <= PW'(by_s1) * PW'(px_s1);
		m2_s2  <= PW'(bx_s1) * PW'(qy_s1);
		m3_s2  <= PW'(by_s1) * PW'(qx_s1);
		m4_s2  <= PW'(px_s1) * PW'(qy_s1);
		m5_s2  <= PW'(py_s1) * PW'(qx_s1);
		bx_s2  <= bx_s1;
		by_s2  <= by_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
	end

	// stage 3: cross products, straddle test, sign normalization, |b|
	logic                 v_s3, ok_s3, sx_s3, sy_s3;
	logic signed [XW-1:0] num_s3, den_s3;
	logic [31:0]          mx_s3, my_s3;
	logic signed [31:0]   ax_s3, ay_s3;
	logic signed [XW-1:0] sc_c, sd_c, nm_c, dn_c;
	logic [DW-1:0]        mx_c, my_c;

	always_comb begin
		sc_c = XW'(m0_s2) - XW'(m1_s2);
		sd_c = XW'(m2_s2) - XW'(m3_s2);
		nm_c = XW'(m4_s2) - XW'(m5_s2);
		dn_c = sd_c - sc_c;
		if (dn_c[XW-1]) begin
			dn_c = -dn_c;
			nm_c = -nm_c;
		end
		// magnitudes of b are below 2^32
		mx_c = bx_s2[DW-1] ? DW'(-bx_s2) : DW'(bx_s2);
		my_c = by_s2[DW-1] ? DW'(-by_s2) : DW'(by_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3  <= !bad_s2 && (sc_c[XW-1] != sd_c[XW-1]);
		num_s3 <= nm_c;
		den_s3 <= dn_c;
		sx_s3  <= bx_s2[DW-1];
		sy_s3  <= by_s2[DW-1];
		mx_s3  <= mx_c[31:0];
		my_s3  <= my_c[31:0];
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
	end

	// stage 4: range test; num split in two halves times |b|
	logic                 v_s4, ok_s4, sx_s4, sy_s4;
	logic signed [31:0]   ax_s4, ay_s4;
	logic [XW-1:0]        den_s4;
	logic [PW-1:0]        plx_s4, phx_s4, ply_s4, phy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4  <= ok_s3 && !num_s3[XW-1] && (num_s3 <= den_s3);
		sx_s4  <= sx_s3;
		sy_s4  <= sy_s3;
		ax_s4  <= ax_s3;
		ay_s4  <= ay_s3;
		den_s4 <= den_s3;
		plx_s4 <= PW'(num_s3[HW-1:0]) * PW'(mx_s3);
		phx_s4 <= PW'(num_s3[XW-1:HW]) * PW'(mx_s3);
		ply_s4 <= PW'(num_s3[HW-1:0]) * PW'(my_s3);
		phy_s4 <= PW'(num_s3[XW-1:HW]) * PW'(my_s3);
	end

	// stage 5: combine partial products into the scaled numerators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctx_out.ok    <= ok_s4;
		ctx_out.neg_x <= sx_s4;
		ctx_out.neg_y <= sy_s4;
		ctx_out.ax    <= ax_s4;
		ctx_out.ay    <= ay_s4;
		nx_out        <= NW'(plx_s4) + (NW'(phx_s4) << HW);
		ny_out        <= NW'(ply_s4) + (NW'(phy_s4) << HW);
		den_out       <= den_s4;
	end

endmodule

/* hw/rtl/sip_div.sv */
// ----------------------------------------------------------------------------
// sip_div: pipelined restoring divider, two quotient bits per stage
// Quotient is below 2^32 since num <= den; computes 2*NST quotient bits, keeps the top QW.
// ----------------------------------------------------------------------------
module sip_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld,
	input  sip_pkg::sip_ctx_t       ctx,
	input  logic [sip_pkg::NW-1:0]  nx,
	input  logic [sip_pkg::NW-1:0]  ny,
	input  logic [sip_pkg::XW-1:0]  den,
	output logic                    vld_out,
	output sip_pkg::sip_ctx_t       ctx_out,
	output logic [sip_pkg::QW-1:0]  qx_out,
	output logic [sip_pkg::QW-1:0]  qy_out
);

	localparam int QW = sip_pkg::QW;
	localparam int XW = sip_pkg::XW;
	localparam int RW = XW + 1;
	localparam int NST = (QW + 1) / 2;  // stages

	// per-stage state: remainder, remaining numerator bits, quotient
	logic                  v_q  [NST+1];
	sip_pkg::sip_ctx_t     c_q  [NST+1];
	logic [XW-1:0]         d_q  [NST+1];
	logic [RW-1:0]         rx_q [NST+1];
	logic [RW-1:0]         ry_q [NST+1];
	logic [2*NST-1:0]      bx_q [NST+1];
	logic [2*NST-1:0]      by_q [NST+1];
	logic [2*NST-1:0]      qxs_q[NST+1];
	logic [2*NST-1:0]      qys_q[NST+1];

	// entry: high bits form initial remainder (below den since quotient fits)
	always_comb begin
		v_q[0]   = vld;
		c_q[0]   = ctx;
		d_q[0]   = den;
		rx_q[0]  = RW'(nx[sip_pkg::NW-1:QW]);
		ry_q[0]  = RW'(ny[sip_pkg::NW-1:QW]);
		bx_q[0]  = (2*NST)'(nx[QW-1:0]) << (2*NST - QW);
		by_q[0]  = (2*NST)'(ny[QW-1:0]) << (2*NST - QW);
		qxs_q[0] = '0;
		qys_q[0] = '0;
	end

	for (genvar g = 0; g < NST; g++) begin : g_st
		logic [RW-1:0] rx1, ry1, rx2, ry2;
		logic          tx1, ty1, tx2, ty2;

		// two restoring steps per stage
		always_comb begin
			rx1 = {rx_q[g][RW-2:0], bx_q[g][2*NST-1]};
			tx1 = rx1 >= RW'(d_q[g]);
			if (tx1) rx1 = rx1 - RW'(d_q[g]);
			rx2 = {rx1[RW-2:0], bx_q[g][2*NST-2]};
			tx2 = rx2 >= RW'(d_q[g]);
			if (tx2) rx2 = rx2 - RW'(d_q[g]);
			ry1 = {ry_q[g][RW-2:0], by_q[g][2*NST-1]};
			ty1 = ry1 >= RW'(d_q[g]);
			if (ty1) ry1 = ry1 - RW'(d_q[g]);
			ry2 = {ry1[RW-2:0], by_q[g][2*NST-2]};
			ty2 = ry2 >= RW'(d_q[g]);
			if (ty2) ry2 = ry2 - RW'(d_q[g]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[g+1] <= 1'b0;
			end else begin
				v_q[g+1] <= v_q[g];
			end
		end

		always_ff @(posedge clk) begin
			c_q[g+1]   <= c_q[g];
			d_q[g+1]   <= d_q[g];
			rx_q[g+1]  <= rx2;
			ry_q[g+1]  <= ry2;
			bx_q[g+1]  <= {bx_q[g][2*NST-3:0], 2'b00};
			by_q[g+1]  <= {by_q[g][2*NST-3:0], 2'b00};
			qxs_q[g+1] <= {qxs_q[g][2*NST-3:0], tx1, tx2};
			qys_q[g+1] <= {qys_q[g][2*NST-3:0], ty1, ty2};
		end
	end

	assign vld_out = v_q[NST];
	assign ctx_out = c_q[NST];
	assign qx_out  = qxs_q[NST][2*NST-1 -: QW];
	assign qy_out  = qys_q[NST][2*NST-1 -: QW];

endmodule

/* hw/rtl/segment_intersection_point.sv */
// ----------------------------------------------------------------------------
// segment_intersection_point: 2D segment crossing test in Q16.16
// Reports whether segment C-D crosses segment A-B and the crossing point.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted at a rising edge with start high; busy is
//   always low, so one transaction may enter every cycle.
//   Each result appears on res for exactly one cycle with done high, in
//   input order. The receiver cannot stall; results are never held.
//   Pipeline: 5 front stages (differences, products, cross products,
//   range test with partial products, scaled numerators), 17 divider
//   stages and the output register.
//   Throughput: one transaction per cycle; the divider is fully pipelined
//   at two quotient bits per stage.
//   No hit gives cross_x = cross_y = 0.
//   Reset clears all valid bits; items in flight are dropped. The block
//   has no other state.
// ----------------------------------------------------------------------------
module segment_intersection_point (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sip_pkg::sip_in_t     din,
	output logic                 done,
	output sip_pkg::sip_out_t    res
);

	logic                       f_vld, d_vld;
	sip_pkg::sip_ctx_t          f_ctx, d_ctx;
	logic [sip_pkg::NW-1:0]     f_nx, f_ny;
	logic [sip_pkg::XW-1:0]     f_den;
	logic [sip_pkg::QW-1:0]     qx, qy;

	assign busy = 1'b0;

	sip_front u_front (
		.clk, .arst_n, .vld(start && !busy), .din,
		.vld_out(f_vld), .ctx_out(f_ctx), .nx_out(f_nx), .ny_out(f_ny),
		.den_out(f_den)
	);

	sip_div u_div (
		.clk, .arst_n, .vld(f_vld), .ctx(f_ctx), .nx(f_nx), .ny(f_ny),
		.den(f_den), .vld_out(d_vld), .ctx_out(d_ctx), .qx_out(qx), .qy_out(qy)
	);

	// output register: sign restore and offset by A
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		res.hit     <= d_ctx.ok;
		res.cross_x <= d_ctx.ok ? d_ctx.ax + (d_ctx.neg_x ? -qx[31:0] : qx[31:0]) : '0;
		res.cross_y <= d_ctx.ok ? d_ctx.ay + (d_ctx.neg_y ? -qy[31:0] : qy[31:0]) : '0;
	end

	// checks
	a_nohit_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.hit |-> res.cross_x == '0 && res.cross_y == '0)
		else $error("no-hit result not zero");
	a_done_follows : assert property (@(posedge clk) disable iff (!arst_n)
		d_vld |=> done)
		else $error("result lost at output");
	a_never_busy : assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule
